@@ rtl/psfm_pkg.sv @@
// Shared types and constants of the planar span fill masker.
package psfm_pkg;

  localparam int unsigned NumCmd = 3;

  typedef logic [1:0] cmd_cnt_t;

  typedef enum logic [0:0] {
    CfgRowStride = 1'b0,
    CfgDrawBase  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]  mask;
    logic [15:0] addr;
    logic [8:0]  count;
  } psfm_cmd_t;

  localparam logic [3:0] HeadMask [4] = '{4'h F, 4'h E, 4'h C, 4'h 8};
  localparam logic [3:0] TailMask [4] = '{4'h 1, 4'h 3, 4'h 7, 4'h F};

  localparam logic [3:0] DitherEven = 4'h5;
  localparam logic [3:0] DitherOdd  = 4'hA;
  localparam logic [3:0] FullMask   = 4'hF;

  localparam logic [10:0] RowStrideReset = 11'd80;
  localparam logic [15:0] DrawBaseReset  = 16'd0;

endpackage

@@ rtl/planar_span_fill_masker.sv @@
// Span to plane-masked write command converter for a four-plane display.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  span in  | start_i, busy_o        | start_x_i end_x_i row_i fill_color_i
//           |                        | color_offset_i glass_i
//  cmd out  | cmd_valid_o (strobe)   | plane_mask_o byte_address_o write_color_o
//           |                        | byte_count_o last_o
//  config   | cfg_we_i               | cfg_index_i cfg_data_i
//
// A span is registered with its row base (one multiply and add) on transfer, then
// expanded into up to three commands held in a command buffer that shifts one out
// per cycle. Before its first command leaves, a span passes the held-span registers
// and then the command buffer, and waits longer while earlier commands still leave.
// The held span moves into the buffer when it holds at most one command, and busy_o
// stays high while a span waits on a fuller buffer, so a new span can be taken
// while commands of earlier spans are still leaving.
// Reset clears the registers to stride 80, base 0 and an empty pipeline.
// Commands leave on the strobe without backpressure.
module planar_span_fill_masker #(
  parameter int unsigned ADDR_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [9:0]  start_x_i,
  input  logic [9:0]  end_x_i,
  input  logic [9:0]  row_i,
  input  logic [7:0]  fill_color_i,
  input  logic [7:0]  color_offset_i,
  input  logic        glass_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        cmd_valid_o,
  output logic [3:0]  plane_mask_o,
  output logic [15:0] byte_address_o,
  output logic [7:0]  write_color_o,
  output logic [8:0]  byte_count_o,
  output logic        last_o
);
  import psfm_pkg::*;

  localparam int unsigned SumW = (ADDR_WIDTH > 22) ? ADDR_WIDTH : 22;
  localparam int unsigned MaxW = (ADDR_WIDTH > 16) ? ADDR_WIDTH : 16;

  function automatic logic [15:0] to_addr16(logic [ADDR_WIDTH-1:0] a);
    logic [MaxW-1:0] w;
    w = MaxW'(a);
    return w[15:0];
  endfunction

  logic [10:0] row_stride_q;
  logic [15:0] draw_base_q;

  logic                  a_valid_q;
  logic [9:0]            a_x1_q, a_x2_q;
  logic                  a_row_odd_q;
  logic [7:0]            a_color_q;
  logic                  a_glass_q;
  logic [ADDR_WIDTH-1:0] a_base_q;

  psfm_cmd_t cmd_q [NumCmd];
  psfm_cmd_t cmd_d [NumCmd];
  cmd_cnt_t  cnt_q, cnt_d;
  logic [7:0] color_q;

  logic        take;
  logic        load;
  logic [20:0] prod;
  logic [SumW-1:0] base_sum;

  logic [7:0]  sb, eb, run_sb;
  logic [1:0]  h, t;
  logic        hp, tp;
  logic [3:0]  dither;
  logic [8:0]  run_cnt;
  logic [ADDR_WIDTH-1:0] addr_sb, addr_eb, addr_run;

  assign load   = (cnt_q == 2'd0) || (cnt_q == 2'd1);
  assign busy_o = a_valid_q && !load;
  assign take   = start_i && !busy_o;

  assign prod     = 21'(row_i) * 21'(row_stride_q);
  assign base_sum = SumW'(draw_base_q) + SumW'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_stride_q <= RowStrideReset;
      draw_base_q  <= DrawBaseReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgRowStride: row_stride_q <= cfg_data_i[10:0];
        CfgDrawBase:  draw_base_q  <= cfg_data_i;
        default:      row_stride_q <= row_stride_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (take) begin
      a_valid_q <= 1'b1;
    end else if (load) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_x1_q      <= start_x_i;
      a_x2_q      <= end_x_i;
      a_row_odd_q <= row_i[0];
      a_glass_q   <= glass_i;
      a_color_q   <= glass_i ? (fill_color_i | color_offset_i) : fill_color_i;
      a_base_q    <= base_sum[ADDR_WIDTH-1:0];
    end
  end

  assign sb     = a_x1_q[9:2];
  assign eb     = a_x2_q[9:2];
  assign h      = a_x1_q[1:0];
  assign t      = a_x2_q[1:0];
  assign hp     = (h != 2'd0);
  assign tp     = (t != 2'd3);
  assign run_sb = hp ? (sb + 8'd1) : sb;
  assign dither = a_glass_q ? (a_row_odd_q ? DitherOdd : DitherEven) : FullMask;
  assign run_cnt = {1'b0, eb} - {1'b0, sb} + 9'd1 - {8'd0, hp} - {8'd0, tp};

  assign addr_sb  = a_base_q + ADDR_WIDTH'(sb);
  assign addr_eb  = a_base_q + ADDR_WIDTH'(eb);
  assign addr_run = a_base_q + ADDR_WIDTH'(run_sb);

  psfm_cmd_t new_cmd [NumCmd];
  cmd_cnt_t  new_cnt;

  always_comb begin
    for (int i = 0; i < NumCmd; i++) begin
      new_cmd[i] = '0;
    end
    new_cnt = 2'd0;
    if (a_valid_q && (a_x1_q <= a_x2_q)) begin
      if (sb == eb) begin
        new_cmd[0].mask  = HeadMask[h] & TailMask[t] & dither;
        new_cmd[0].addr  = to_addr16(addr_sb);
        new_cmd[0].count = 9'd1;
        new_cnt = 2'd1;
      end else begin
        if (hp) begin
          new_cmd[new_cnt].mask  = HeadMask[h] & dither;
          new_cmd[new_cnt].addr  = to_addr16(addr_sb);
          new_cmd[new_cnt].count = 9'd1;
          new_cnt = new_cnt + 2'd1;
        end
        if (tp) begin
          new_cmd[new_cnt].mask  = TailMask[t] & dither;
          new_cmd[new_cnt].addr  = to_addr16(addr_eb);
          new_cmd[new_cnt].count = 9'd1;
          new_cnt = new_cnt + 2'd1;
        end
        if (run_cnt != 9'd0) begin
          new_cmd[new_cnt].mask  = FullMask & dither;
          new_cmd[new_cnt].addr  = to_addr16(addr_run);
          new_cmd[new_cnt].count = run_cnt;
          new_cnt = new_cnt + 2'd1;
        end
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < NumCmd; i++) begin
      cmd_d[i] = cmd_q[i];
    end
    if (load) begin
      cnt_d = new_cnt;
      for (int i = 0; i < NumCmd; i++) begin
        cmd_d[i] = new_cmd[i];
      end
    end else begin
      cnt_d = cnt_q - 2'd1;
      for (int i = 0; i < NumCmd - 1; i++) begin
        cmd_d[i] = cmd_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumCmd; i++) begin
      cmd_q[i] <= cmd_d[i];
    end
    if (load && a_valid_q) begin
      color_q <= a_color_q;
    end
  end

  assign cmd_valid_o    = (cnt_q != 2'd0);
  assign plane_mask_o   = cmd_q[0].mask;
  assign byte_address_o = cmd_q[0].addr;
  assign byte_count_o   = cmd_q[0].count;
  assign write_color_o  = color_q;
  assign last_o         = (cnt_q == 2'd1);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o && !last_o |=> cmd_valid_o)
    else $error("command run of a span broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (cnt_q == 2'd2) || (cnt_q == 2'd3))
    else $error("busy while buffer can take a span");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> byte_count_o != 9'd0)
    else $error("command with zero byte count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> a_valid_q)
    else $error("transferred span not held");

endmodule
